// File: hdl/lis_length_patience_tails_macros.svh
// Assertion macros used by the checker file.
`ifndef LIS_LENGTH_PATIENCE_TAILS_MACROS_SVH
`define LIS_LENGTH_PATIENCE_TAILS_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LIS_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LIS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: hdl/lis_pkg.sv
// Shared constants and types for the patience-sorting LIS block.
package lis_pkg;

  localparam int MAX_LEN     = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int LEN_W       = $clog2(MAX_LEN + 1);

  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((LEN_W + 7) / 8) * 8;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [LEN_W-1:0]              len_t;

  // Status handed from one cell to the next one up the row.
  typedef struct packed {
    logic valid;  // cell holds a tail in use
    logic ge;     // cell holds a tail >= incoming key
  } link_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic   accept;
    value_t key;
  } cell_ctrl_t;

endpackage

// File: hdl/lis_length_patience_tails.sv
// Top level: LIS length by patience sorting over a row of tail cells.
//
//  channel | dir | beat payload
//  --------+-----+----------------------------------------------
//  in_     | in  | tdata = value, tlast = last
//  out_    | out | tdata = length, tuser = overflow, tlast = final_res
//
// One beat per cycle: every cell compares its tail with the key at once and
// passes its compare flag to the next cell, so the key finds its slot in the
// accept cycle; the result is registered and shows the following cycle.
// Reset clears the used count, the overflow flag and the output valid; tails need no reset.
// The input stalls only while a result waits on a low out_tready.
module lis_length_patience_tails (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lis_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] value
  input  logic                             in_tlast,   // last
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lis_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [6:0] length, [7] zero
  output logic                             out_tuser,  // [0] overflow
  output logic                             out_tlast   // final_res
);
  import lis_pkg::*;

  len_t       used_r, used_nxt;
  logic       ovf_seen_r, ovf_seen_nxt;
  logic       out_valid_r, out_valid_nxt;
  len_t       out_len_r, out_len_nxt;
  logic       out_ovf_r, out_ovf_nxt;
  logic       out_last_r, out_last_nxt;

  logic       accept;
  cell_ctrl_t ctrl;
  link_t      links [MAX_LEN+1];
  logic [MAX_LEN-1:0] ge_vec;
  logic       any_ge;
  logic       full;
  logic       append;
  len_t       len_after;
  logic       ovf_after;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign ctrl.accept = accept;
  assign ctrl.key    = in_tdata[VALUE_WIDTH-1:0];

  // Virtual cell below the row: always in use, always below the key.
  assign links[0].valid = 1'b1;
  assign links[0].ge    = 1'b0;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    lis_cell u_cell (
      .clk     (clk),
      .ctrl_i  (ctrl),
      .valid_i (used_r > len_t'(k)),
      .prev_i  (links[k]),
      .link_o  (links[k+1])
    );
    assign ge_vec[k] = links[k+1].ge;
  end

  assign any_ge    = |ge_vec;
  assign full      = (used_r == len_t'(MAX_LEN));
  assign append    = !any_ge && !full;
  assign len_after = used_r + len_t'(append);
  assign ovf_after = ovf_seen_r || (!any_ge && full);

  always_comb begin
    used_nxt      = used_r;
    ovf_seen_nxt  = ovf_seen_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_len_nxt   = out_len_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    if (accept) begin
      used_nxt      = in_tlast ? '0 : len_after;
      ovf_seen_nxt  = in_tlast ? 1'b0 : ovf_after;
      out_valid_nxt = 1'b1;
      out_len_nxt   = len_after;
      out_ovf_nxt   = ovf_after;
      out_last_nxt  = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      ovf_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      ovf_seen_r  <= ovf_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_len_r  <= out_len_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_len_r);
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

endmodule

// File: hdl/lis_cell.sv
// One tail cell: holds one tail, compares it with the broadcast key.
module lis_cell (
  input  logic                clk,
  input  lis_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  lis_pkg::link_t      prev_i,
  output lis_pkg::link_t      link_o
);
  import lis_pkg::*;

  value_t tail_r;
  value_t tail_nxt;
  logic   ge;
  logic   wr_en;

  assign ge = valid_i && (tail_r >= ctrl_i.key);

  // Lower bound: first cell at or above the key, or the first free cell
  // when every tail in use is below the key.
  assign wr_en = ctrl_i.accept && !prev_i.ge && (ge || (!valid_i && prev_i.valid));

  assign tail_nxt = wr_en ? ctrl_i.key : tail_r;

  assign link_o.valid = valid_i;
  assign link_o.ge    = ge;

  always_ff @(posedge clk) begin
    tail_r <= tail_nxt;
  end

endmodule

// File: hdl/lis_chk.sv
// Port-level checker for the LIS block, bound to the top level.
`include "lis_length_patience_tails_macros.svh"

module lis_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lis_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);
  import lis_pkg::*;

  len_t out_len;
  assign out_len = out_tdata[LEN_W-1:0];

  `LIS_ASSERT_NOW(a_len_range, out_tvalid, out_len <= len_t'(MAX_LEN), "length above table size")
  `LIS_ASSERT_NOW(a_ovf_full, out_tvalid && out_tuser, out_len == len_t'(MAX_LEN), "overflow without full table")
  `LIS_ASSERT_NEXT(a_last_result, in_tvalid && in_tready && in_tlast, out_tvalid && out_tlast, "closing beat lost its result")
  `LIS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind lis_length_patience_tails lis_chk u_lis_chk (.*);

// File: bench/lis_length_patience_tails_tb.sv
// Testbench for the patience-sorting LIS length block: directed and random sequences, checked per beat.
`timescale 1ns / 1ps

module lis_length_patience_tails_tb;
  import lis_pkg::*;

  typedef struct {
    value_t value;
    logic   last;
  } lis_beat_t;

  typedef struct {
    len_t length;
    logic overflow;
    logic final_res;
  } lis_result_t;

  localparam value_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam value_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam int     N_ITEMS = 1750;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  lis_beat_t   value_q[$];
  lis_result_t length_expect_q[$];

  // predictor state
  value_t tails[MAX_LEN];
  int     tails_used;
  logic   full_dropped;

  int beats_in;
  int fail_cnt;
  bit in_taken;

  lis_length_patience_tails i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Lower-bound insert into the tails table; returns the result this beat yields.
  function automatic lis_result_t update_tails(value_t v, logic last);
    lis_result_t res;
    int          pos;
    pos = 0;
    while (pos < tails_used && tails[pos] < v) pos++;
    if (pos < tails_used) begin
      tails[pos] = v;
    end else if (tails_used < MAX_LEN) begin
      tails[tails_used] = v;
      tails_used++;
    end else begin
      full_dropped = 1'b1;
    end
    res.length    = len_t'(tails_used);
    res.overflow  = full_dropped;
    res.final_res = last;
    if (last) begin
      tails_used   = 0;
      full_dropped = 1'b0;
    end
    return res;
  endfunction

  // idle pattern rotates every 220 accepted beats: none, sender, receiver, both
  function automatic bit sender_idles();
    int phase;
    phase = (beats_in / 220) % 4;
    if (phase == 1) return $urandom_range(0, 99) < 61;
    if (phase == 3) return $urandom_range(0, 99) < 38;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    int phase;
    phase = (beats_in / 220) % 4;
    if (phase == 2) return $urandom_range(0, 99) < 61;
    if (phase == 3) return $urandom_range(0, 99) < 38;
    return 1'b0;
  endfunction

  task automatic queue_value(value_t v, logic last);
    lis_beat_t b;
    b.value = v;
    b.last  = last;
    value_q = {value_q, b};
  endtask

  // driver
  always @(negedge clk) begin
    lis_beat_t b;
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (value_q.size() > 0 && !sender_idles()) begin
          b = value_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= b.value;
          in_tlast  <= b.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      in_taken = 1'b0;
      out_tready <= !receiver_stalls();
    end
  end

  // monitor: predicts on input beats, checks output beats
  always @(posedge clk) begin
    lis_result_t exp_res;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        exp_res = update_tails(value_t'(in_tdata), in_tlast);
        length_expect_q = {length_expect_q, exp_res};
        beats_in++;
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (length_expect_q.size() == 0) begin
          $display("%0t: unexpected result beat tdata=%0h tuser=%b tlast=%b",
                   $time, out_tdata, out_tuser, out_tlast);
          fail_cnt++;
        end else begin
          exp_res = length_expect_q.pop_front();
          if (out_tdata !== OUT_TDATA_W'(exp_res.length)) begin
            $display("%0t: length expected %0d, got %0d",
                     $time, exp_res.length, out_tdata);
            fail_cnt++;
          end
          if (out_tuser !== exp_res.overflow) begin
            $display("%0t: overflow expected %b, got %b",
                     $time, exp_res.overflow, out_tuser);
            fail_cnt++;
          end
          if (out_tlast !== exp_res.final_res) begin
            $display("%0t: final expected %b, got %b",
                     $time, exp_res.final_res, out_tlast);
            fail_cnt++;
          end
        end
      end
    end
  end

  initial begin
    int     seq_len;
    int     kind;
    int     drain;
    value_t v;

    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    out_tready   = 1'b0;
    tails_used   = 0;
    full_dropped = 1'b0;
    beats_in     = 0;
    fail_cnt     = 0;
    in_taken     = 1'b0;

    // directed: extremes, equal values, single-beat and falling sequences
    queue_value(0, 1'b0);
    queue_value(-1, 1'b0);
    queue_value(VAL_MAX, 1'b0);
    queue_value(VAL_MIN, 1'b1);
    queue_value(5, 1'b0);
    queue_value(5, 1'b0);
    queue_value(5, 1'b1);
    queue_value(VAL_MAX, 1'b0);
    queue_value(VAL_MIN, 1'b0);
    queue_value(VAL_MAX, 1'b0);
    queue_value(VAL_MIN, 1'b0);
    queue_value(0, 1'b1);
    queue_value(VAL_MIN, 1'b1);
    queue_value(VAL_MAX, 1'b1);
    queue_value(3, 1'b0);
    queue_value(2, 1'b0);
    queue_value(1, 1'b0);
    queue_value(0, 1'b1);
    queue_value(VAL_MIN, 1'b0);
    queue_value(VAL_MIN + 1, 1'b0);
    queue_value(VAL_MAX - 1, 1'b0);
    queue_value(VAL_MAX, 1'b1);

    // random sequences; long ramps push the table past full
    while (value_q.size() < N_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        seq_len = $urandom_range(1, 24);
        for (int i = 0; i < seq_len; i++)
          queue_value(value_t'($urandom), i == seq_len - 1);
      end else if (kind < 5) begin
        seq_len = $urandom_range(1, 30);
        for (int i = 0; i < seq_len; i++)
          queue_value(value_t'($urandom_range(0, 7)) - 4, i == seq_len - 1);
      end else if (kind < 8) begin
        // rising run, sometimes with repeats, then a random tail of up to five values
        seq_len = $urandom_range(60, 72);
        drain   = $urandom_range(0, 5);
        v = (kind == 7) ? VAL_MIN : value_t'($urandom_range(0, 1 << 20)) - (1 << 19);
        for (int i = 0; i < seq_len; i++) begin
          queue_value(v, (drain == 0) && (i == seq_len - 1));
          v = v + value_t'($urandom_range((kind == 6) ? 0 : 1, 1000));
        end
        for (int i = 0; i < drain; i++)
          queue_value(value_t'($urandom), i == drain - 1);
      end else begin
        seq_len = $urandom_range(1, 20);
        for (int i = 0; i < seq_len; i++) begin
          case ($urandom_range(0, 3))
            0:       v = VAL_MIN;
            1:       v = VAL_MAX;
            default: v = value_t'($urandom_range(0, 40)) - 20;
          endcase
          queue_value(v, i == seq_len - 1);
        end
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (value_q.size() > 0 || in_tvalid) @(posedge clk);
    drain = 0;
    while (length_expect_q.size() > 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);

    if (fail_cnt == 0 && length_expect_q.size() == 0) begin
      $display("lis_length_patience_tails test passed");
    end else begin
      if (length_expect_q.size() > 0)
        $display("%0t: %0d expected results never arrived", $time, length_expect_q.size());
      $display("lis_length_patience_tails test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("lis_length_patience_tails test failed");
    $finish;
  end

endmodule
